>>> src/b64d_pkg.sv
// Shared types, alphabet constants and character-to-sextet mapping for the base64 decoder.
`default_nettype none
package b64d_pkg;

   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
   localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;

   localparam logic [5:0] LOWER_BASE   = 6'd26;
   localparam logic [5:0] DIGIT_BASE   = 6'd52;
   localparam logic [5:0] PLUS_VALUE   = 6'd62;
   localparam logic [5:0] MINUS_VALUE  = 6'd63;

   localparam logic [15:0] MAX_LEN_RESET = 16'hFFFF;

   localparam logic OP_CHAR = 1'b0;
   localparam logic OP_END  = 1'b1;

   typedef struct packed {
      logic [5:0]  res_bits;
      logic [2:0]  res_count;
      logic [15:0] bytes_written;
   } state_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        last;
      logic        stored;
      logic [15:0] written_count;
   } result_type;

   typedef struct packed {
      logic       valid;
      logic [5:0] value;
   } sextet_type;

   function automatic sextet_type sextet_of(input logic [7:0] c);
      sextet_type s;
      s.valid = 1'b1;
      s.value = '0;
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         s.value = 6'(c - CHAR_UPPER_A);
      end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
         s.value = 6'(c - CHAR_LOWER_A) + LOWER_BASE;
      end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
         s.value = 6'(c - CHAR_DIGIT_0) + DIGIT_BASE;
      end else if (c == CHAR_PLUS) begin
         s.value = PLUS_VALUE;
      end else if (c == CHAR_MINUS) begin
         s.value = MINUS_VALUE;
      end else begin
         s.valid = 1'b0;
      end
      return s;
   endfunction

endpackage
`default_nettype wire

>>> src/b64d_decode.sv
// Combinational decode step: next accumulator state and result for one beat.
`default_nettype none
module b64d_decode (
   input  wire logic                 op,
   input  wire logic [7:0]           text_char,
   input  wire logic [15:0]          max_len,
   input  wire b64d_pkg::state_type  state_cur,
   output b64d_pkg::state_type       state_next,
   output b64d_pkg::result_type      result,
   output logic                      has_result
);
   import b64d_pkg::*;

   sextet_type  sx;
   logic [11:0] acc;
   logic [2:0]  shift;
   logic [5:0]  keep_mask;
   logic        room;
   logic [15:0] count_inc;

   assign sx        = sextet_of(text_char);
   assign acc       = {state_cur.res_bits, sx.value};
   assign shift     = state_cur.res_count - 3'd2;
   assign keep_mask = 6'((7'd1 << shift) - 7'd1);
   assign room      = state_cur.bytes_written < max_len;
   assign count_inc = room ? state_cur.bytes_written + 16'd1 : state_cur.bytes_written;

   always_comb begin
      state_next           = state_cur;
      result.out_byte      = 8'd0;
      result.last          = 1'b0;
      result.stored        = room;
      result.written_count = count_inc;
      has_result           = 1'b0;
      if (op == OP_END) begin
         result.last = 1'b1;
         has_result  = 1'b1;
         state_next  = '0;
      end else if (sx.valid) begin
         if (state_cur.res_count < 3'd2) begin
            state_next.res_bits  = sx.value;
            state_next.res_count = state_cur.res_count + 3'd6;
         end else begin
            result.out_byte          = 8'(acc >> shift);
            has_result               = 1'b1;
            state_next.res_bits      = acc[5:0] & keep_mask;
            state_next.res_count     = shift;
            state_next.bytes_written = count_inc;
         end
      end
   end

endmodule
`default_nettype wire

>>> src/base64_stream_decoder.sv
// Top level of the base64 stream decoder: input register, decode step, result register.
//
// Usage:
//   req_ channel carries one character (req_op = 0) or an end-of-string
//   marker (req_op = 1) per beat. rsp_ channel returns at most one result
//   per request beat: a decoded byte, or the end-of-string beat with the
//   terminator, rsp_last = 1 and the final written count. Characters outside
//   the alphabet and characters that complete no byte give no result.
//   csr_ writes max_len; csr_ready is always high. Write only while idle.
// Path: a request beat is taken into the input register, and its result
//   is then loaded into the result register.
// Throughput: one request beat per cycle while req_stall is low; the decode
//   step between the two registers is a single pass, so nothing iterates.
// Reset: clears the valid flags of both registers, the residual bits, the
//   byte count, and sets max_len to 65535.
// Stall: rsp_stall holds the result register; the input register then
//   holds too only if its beat would produce a result, and req_stall rises.
`default_nettype none
module base64_stream_decoder (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_op,
   input  wire logic [7:0]  req_text_char,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_last,
   output logic             rsp_stored,
   output logic [15:0]      rsp_written_count,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [15:0] csr_max_len
);
   import b64d_pkg::*;

   logic        in_valid_ff, in_valid_in;
   logic        in_op_ff;
   logic [7:0]  in_char_ff;
   logic        out_valid_ff, out_valid_in;
   result_type  out_ff;
   state_type   state_ff, state_in;
   logic [15:0] max_len_ff;
   result_type  dec_result;
   logic        dec_has_result;
   logic        advance;
   logic        req_take;

   b64d_decode u_decode (
      .op         (in_op_ff),
      .text_char  (in_char_ff),
      .max_len    (max_len_ff),
      .state_cur  (state_ff),
      .state_next (state_in),
      .result     (dec_result),
      .has_result (dec_has_result)
   );

   assign advance   = in_valid_ff && (!dec_has_result || !out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   always_comb begin
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      if (advance && dec_has_result) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
         max_len_ff   <= MAX_LEN_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
         if (csr_valid && csr_ready) begin
            max_len_ff <= csr_max_len;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_op_ff   <= req_op;
         in_char_ff <= req_text_char;
      end
      if (advance && dec_has_result) begin
         out_ff <= dec_result;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_out_byte      = out_ff.out_byte;
   assign rsp_last          = out_ff.last;
   assign rsp_stored        = out_ff.stored;
   assign rsp_written_count = out_ff.written_count;

endmodule
`default_nettype wire
